// ===== hw/rtl/supply_type_and_battery_gauge_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the supply gauge RTL
// Each macro expects signals named clock and reset in the calling scope.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_TYPE_AND_BATTERY_GAUGE_TOP_MACROS_SVH
`define SUPPLY_TYPE_AND_BATTERY_GAUGE_TOP_MACROS_SVH

// same-cycle implication
`define STBG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STBG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stbg_pkg.sv =====
// ----------------------------------------------------------------------------
// stbg_pkg
// Types and constants shared by the supply type and battery gauge modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stbg_pkg;

   // field widths
   localparam int ADC_W    = 10;
   localparam int MV_W     = 21;
   localparam int CNT_W    = 4;
   localparam int PCT_W    = 7;
   localparam int ALERT_W  = 2;
   localparam int DIFF_W   = 13;
   localparam int MULK_W   = 7;

   // divider runs one quotient bit per cycle over the full dividend
   localparam int DIV_STEPS = MV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // constants of the gauge
   localparam logic [MV_W-1:0]  MV_NUMERATOR   = 21'd1125300;
   localparam logic [CNT_W-1:0] CONFIRM_RESET  = 4'd3;
   localparam logic [CNT_W-1:0] CONFIRM_SAT    = 4'd15;
   localparam logic [MV_W-1:0]  MAINS_LO_MV    = 21'd3150;
   localparam logic [MV_W-1:0]  MAINS_HI_MV    = 21'd3425;
   localparam logic [MV_W-1:0]  LI_FULL_MV     = 21'd4200;
   localparam logic [MV_W-1:0]  LI_KNEE_HI_MV  = 21'd3950;
   localparam logic [MV_W-1:0]  LI_KNEE_LO_MV  = 21'd3600;
   localparam logic [MV_W-1:0]  EMPTY_MV       = 21'd2700;
   localparam logic [MV_W-1:0]  AA_CLAMP_MV    = 21'd3154;
   localparam logic [MV_W-1:0]  LI_CRIT_MV     = 21'd3000;
   localparam logic [MV_W-1:0]  LI_LOW_MV      = 21'd3500;
   localparam logic [MV_W-1:0]  AA_CRIT_MV     = 21'd2740;
   localparam logic [MV_W-1:0]  AA_LOW_MV      = 21'd2775;
   localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;
   localparam logic [PCT_W-1:0] PCT_ERROR      = 7'd101;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_MAINS   = 2'd1,
      KIND_LITHIUM = 2'd2,
      KIND_AA      = 2'd3
   } stbg_kind_type;

   typedef enum logic [ALERT_W-1:0] {
      ALERT_NONE = 2'd0,
      ALERT_LOW  = 2'd1,
      ALERT_CRIT = 2'd2
   } stbg_alert_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MV,
      ST_CLASSIFY,
      ST_MAP,
      ST_DIV_PCT,
      ST_EMIT
   } stbg_state_type;

   // divider request / response
   typedef struct packed {
      logic             start;
      logic [MV_W-1:0]  dividend;
      logic [ADC_W-1:0] divisor;
   } stbg_div_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [MV_W-1:0] quotient;
   } stbg_div_rsp_type;

   // reserve map segment chosen for one reading
   typedef struct packed {
      logic             need_div;
      logic [MV_W-1:0]  dividend;
      logic [ADC_W-1:0] divisor;
      logic [PCT_W-1:0] offset;
      logic [PCT_W-1:0] direct_pct;
      stbg_alert_type   alert;
   } stbg_map_type;

endpackage

// ===== hw/rtl/stbg_div.sv =====
// ----------------------------------------------------------------------------
// stbg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "supply_type_and_battery_gauge_top_macros.svh"

module stbg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  stbg_pkg::stbg_div_req_type div_req,
   output stbg_pkg::stbg_div_rsp_type div_rsp
);
   import stbg_pkg::*;

   logic [MV_W-1:0]      quot_ff, quot_in;
   logic [ADC_W-1:0]     rem_ff, rem_in;
   logic [ADC_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ADC_W:0]       trial;
   logic                 fits;

   // one shift-subtract step
   assign trial = {rem_ff, quot_ff[MV_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;
      if (div_req.start) begin
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in    = 1'b1;
         done_in    = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[MV_W-2:0], fits};
         rem_in  = fits ? ADC_W'(trial - {1'b0, divisor_ff}) : trial[ADC_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   `STBG_ASSERT_NEXT(a_div_start, div_req.start, busy_ff && !done_ff, "divider did not start")
   `STBG_ASSERT_NOW(a_div_excl, busy_ff, !done_ff, "divider busy and done together")
   `STBG_ASSERT_NOW(a_div_rem, busy_ff, rem_ff < divisor_ff, "partial remainder out of range")

endmodule

// ===== hw/rtl/stbg_map.sv =====
// ----------------------------------------------------------------------------
// stbg_map
// Picks the reserve map segment and alert level for a kind and voltage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbg_map (
   input  stbg_pkg::stbg_kind_type kind,
   input  logic [20:0]             mv,
   output stbg_pkg::stbg_map_type  seg
);
   import stbg_pkg::*;

   logic [DIFF_W-1:0]        lo;
   logic [MULK_W-1:0]        mul_k;
   logic [DIFF_W-1:0]        diff;
   logic [DIFF_W+MULK_W-1:0] prod;
   logic [DIFF_W-1:0]        under;

   assign under = EMPTY_MV[DIFF_W-1:0] - mv[DIFF_W-1:0];

   always_comb begin
      lo             = EMPTY_MV[DIFF_W-1:0];
      mul_k          = MULK_W'(20);
      seg.need_div   = 1'b0;
      seg.divisor    = ADC_W'(900);
      seg.offset     = '0;
      seg.direct_pct = '0;
      seg.alert      = ALERT_NONE;
      case (kind)
         KIND_MAINS: begin
            seg.direct_pct = PCT_FULL;
         end
         KIND_LITHIUM: begin
            if (mv > LI_FULL_MV) begin
               seg.direct_pct = PCT_FULL;
            end else if (mv > LI_KNEE_HI_MV) begin
               lo           = LI_KNEE_HI_MV[DIFF_W-1:0];
               mul_k        = MULK_W'(20);
               seg.divisor  = ADC_W'(250);
               seg.offset   = PCT_W'(80);
               seg.need_div = 1'b1;
            end else if (mv > LI_KNEE_LO_MV) begin
               lo           = LI_KNEE_LO_MV[DIFF_W-1:0];
               mul_k        = MULK_W'(60);
               seg.divisor  = ADC_W'(350);
               seg.offset   = PCT_W'(20);
               seg.need_div = 1'b1;
            end else if (mv > EMPTY_MV) begin
               seg.need_div = 1'b1;
            end
            if (mv < LI_CRIT_MV) begin
               seg.alert = ALERT_CRIT;
            end else if (mv < LI_LOW_MV) begin
               seg.alert = ALERT_LOW;
            end
         end
         KIND_AA: begin
            mul_k       = MULK_W'(100);
            seg.divisor = ADC_W'(450);
            if (mv > AA_CLAMP_MV) begin
               seg.direct_pct = PCT_ERROR;
            end else if (mv >= EMPTY_MV) begin
               seg.need_div = 1'b1;
            end else if (under > DIFF_W'(4)) begin
               // negative quotient of at least one
               seg.direct_pct = PCT_ERROR;
            end
            if (mv < AA_CRIT_MV) begin
               seg.alert = ALERT_CRIT;
            end else if (mv < AA_LOW_MV) begin
               seg.alert = ALERT_LOW;
            end
         end
         default: begin
            seg.direct_pct = '0;
         end
      endcase
      // scaled distance above the segment base; feeds the divider
      diff         = mv[DIFF_W-1:0] - lo;
      prod         = diff * mul_k;
      seg.dividend = MV_W'(prod);
   end

endmodule

// ===== hw/rtl/stbg_seq.sv =====
// ----------------------------------------------------------------------------
// stbg_seq
// Sequencer: drives the shared divider, updates supply type, holds result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "supply_type_and_battery_gauge_top_macros.svh"

module stbg_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [9:0]                 req_adc_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [20:0]                rsp_supply_mv,
   output logic [1:0]                 rsp_supply_kind,
   output logic [3:0]                 rsp_confirm_count,
   output logic [6:0]                 rsp_reserve_pct,
   output logic [1:0]                 rsp_alert_level,
   output logic                       rsp_on_mains,
   output logic                       rsp_bad_reading,
   input  logic [3:0]                 confirm_limit,
   output stbg_pkg::stbg_div_req_type div_req,
   input  stbg_pkg::stbg_div_rsp_type div_rsp,
   output stbg_pkg::stbg_kind_type    cur_kind,
   output logic [20:0]                cur_mv,
   input  stbg_pkg::stbg_map_type     seg
);
   import stbg_pkg::*;

   stbg_state_type   state_ff, state_in;
   stbg_kind_type    kind_ff, kind_in;
   stbg_kind_type    seen;
   logic [CNT_W-1:0] agree_ff, agree_in;
   logic [MV_W-1:0]  mv_ff, mv_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   stbg_alert_type   alert_ff, alert_in;
   logic             bad_ff, bad_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_load;

   logic [MV_W-1:0]    out_mv_ff;
   stbg_kind_type      out_kind_ff;
   logic [CNT_W-1:0]   out_count_ff;
   logic [PCT_W-1:0]   out_pct_ff;
   stbg_alert_type     out_alert_ff;
   logic               out_bad_ff;

   // classification of the fresh voltage
   always_comb begin
      if (mv_ff >= MAINS_LO_MV && mv_ff <= MAINS_HI_MV) begin
         seen = KIND_MAINS;
      end else if (mv_ff > MAINS_HI_MV) begin
         seen = KIND_LITHIUM;
      end else begin
         seen = KIND_AA;
      end
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      agree_in     = agree_ff;
      mv_in        = mv_ff;
      pct_in       = pct_ff;
      alert_in     = alert_ff;
      bad_in       = bad_ff;
      out_valid_in = out_valid_ff;
      out_load     = 1'b0;
      div_req      = '0;
      req_ready    = (state_ff == ST_IDLE);

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_adc_count == '0) begin
                  mv_in    = '0;
                  pct_in   = PCT_ERROR;
                  alert_in = ALERT_NONE;
                  bad_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = MV_NUMERATOR;
                  div_req.divisor  = req_adc_count;
                  bad_in           = 1'b0;
                  state_in         = ST_DIV_MV;
               end
            end
         end
         ST_DIV_MV: begin
            if (div_rsp.done) begin
               mv_in    = div_rsp.quotient;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (agree_ff < confirm_limit) begin
               if (kind_ff == KIND_UNKNOWN) begin
                  kind_in  = seen;
                  agree_in = CNT_W'(1);
               end else if (kind_ff == seen) begin
                  if (agree_ff < CONFIRM_SAT) begin
                     agree_in = agree_ff + 1'b1;
                  end
               end else begin
                  kind_in = KIND_UNKNOWN;
               end
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            alert_in = seg.alert;
            if (seg.need_div) begin
               div_req.start    = 1'b1;
               div_req.dividend = seg.dividend;
               div_req.divisor  = seg.divisor;
               state_in         = ST_DIV_PCT;
            end else begin
               pct_in   = seg.direct_pct;
               state_in = ST_EMIT;
            end
         end
         ST_DIV_PCT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient[PCT_W-1:0] + seg.offset;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and supply state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_UNKNOWN;
         agree_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         agree_ff     <= agree_in;
         out_valid_ff <= out_valid_in;
      end
      mv_ff    <= mv_in;
      pct_ff   <= pct_in;
      alert_ff <= alert_in;
      bad_ff   <= bad_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mv_ff    <= mv_ff;
         out_kind_ff  <= kind_ff;
         out_count_ff <= agree_ff;
         out_pct_ff   <= pct_ff;
         out_alert_ff <= alert_ff;
         out_bad_ff   <= bad_ff;
      end
   end

   assign cur_kind          = kind_ff;
   assign cur_mv            = mv_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_supply_mv     = out_mv_ff;
   assign rsp_supply_kind   = out_kind_ff;
   assign rsp_confirm_count = out_count_ff;
   assign rsp_reserve_pct   = out_pct_ff;
   assign rsp_alert_level   = out_alert_ff;
   assign rsp_on_mains      = (out_kind_ff == KIND_MAINS);
   assign rsp_bad_reading   = out_bad_ff;

   `STBG_ASSERT_NEXT(a_start_div, state_ff == ST_IDLE && req_valid && req_adc_count != '0,
      state_ff == ST_DIV_MV && div_rsp.busy, "accepted reading did not start divider")
   `STBG_ASSERT_NEXT(a_frozen, state_ff == ST_CLASSIFY && agree_ff >= confirm_limit,
      $stable(kind_ff) && $stable(agree_ff), "frozen supply type changed")
   `STBG_ASSERT_NOW(a_bad_out, out_valid_ff && out_bad_ff,
      out_mv_ff == '0 && out_pct_ff == PCT_ERROR, "bad reading result not cleared")
   `STBG_ASSERT_NOW(a_pct_range, out_valid_ff, out_pct_ff <= PCT_ERROR, "reserve out of range")

endmodule

// ===== hw/rtl/supply_type_and_battery_gauge_top.sv =====
// ----------------------------------------------------------------------------
// supply_type_and_battery_gauge_top
// Supply voltage, supply type detection and battery reserve gauge.
//
// Usage:
//   req_*  : one ADC bandgap count per beat (valid/ready).
//   rsp_*  : one result beat per request beat (valid/ready), held in an
//            output register until taken.
//   csr_*  : confirm_limit write, no wait; write only while the block is idle.
// A zero count goes straight to the result; other readings run the voltage
//   divide, classification and map, plus a second divide when the reserve
//   does not come straight from the map. Both divides run on one shared
//   radix-2 divider.
// No new request beat is taken while a reading is in work; req_ready is
//   high only while the sequencer is idle.
// Reset clears the supply type, the agree count and the result valid, and
//   loads confirm_limit with 3.
// A stalled receiver holds the result register; the next request is still
//   taken and computed, and then waits until the held beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module supply_type_and_battery_gauge_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_adc_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_supply_mv,
   output logic [1:0]  rsp_supply_kind,
   output logic [3:0]  rsp_confirm_count,
   output logic [6:0]  rsp_reserve_pct,
   output logic [1:0]  rsp_alert_level,
   output logic        rsp_on_mains,
   output logic        rsp_bad_reading,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import stbg_pkg::*;

   logic [CNT_W-1:0] confirm_limit_ff, confirm_limit_in;
   stbg_div_req_type div_req;
   stbg_div_rsp_type div_rsp;
   stbg_kind_type    cur_kind;
   logic [MV_W-1:0]  cur_mv;
   stbg_map_type     seg;

   // confirm limit register
   assign confirm_limit_in = csr_wr_en ? csr_wr_data : confirm_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_limit_ff <= CONFIRM_RESET;
      end else begin
         confirm_limit_ff <= confirm_limit_in;
      end
   end

   stbg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   stbg_map u_map (
      .kind (cur_kind),
      .mv   (cur_mv),
      .seg  (seg)
   );

   stbg_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adc_count     (req_adc_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_supply_mv     (rsp_supply_mv),
      .rsp_supply_kind   (rsp_supply_kind),
      .rsp_confirm_count (rsp_confirm_count),
      .rsp_reserve_pct   (rsp_reserve_pct),
      .rsp_alert_level   (rsp_alert_level),
      .rsp_on_mains      (rsp_on_mains),
      .rsp_bad_reading   (rsp_bad_reading),
      .confirm_limit     (confirm_limit_ff),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .cur_kind          (cur_kind),
      .cur_mv            (cur_mv),
      .seg               (seg)
   );

endmodule

// ===== tb/sv/stbg_gauge_checker.sv =====
// ----------------------------------------------------------------------------
// stbg_gauge_checker
// Watches the request, result and CSR ports of the supply gauge, predicts the
// result of every accepted ADC reading and compares each result beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbg_gauge_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [stbg_pkg::ADC_W-1:0]    req_adc_count,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [stbg_pkg::MV_W-1:0]     rsp_supply_mv,
   input  logic [1:0]                    rsp_supply_kind,
   input  logic [stbg_pkg::CNT_W-1:0]    rsp_confirm_count,
   input  logic [stbg_pkg::PCT_W-1:0]    rsp_reserve_pct,
   input  logic [stbg_pkg::ALERT_W-1:0]  rsp_alert_level,
   input  logic                          rsp_on_mains,
   input  logic                          rsp_bad_reading,
   input  logic                          csr_wr_en,
   input  logic [stbg_pkg::CNT_W-1:0]    csr_wr_data,
   output int unsigned                   fail_count,
   output int unsigned                   outstanding,
   output int unsigned                   beats_checked
);
   import stbg_pkg::*;

   typedef struct packed {
      logic [MV_W-1:0]  mv;
      stbg_kind_type    kind;
      logic [CNT_W-1:0] agree;
      logic [PCT_W-1:0] pct;
      stbg_alert_type   alert;
      logic             mains;
      logic             bad;
   } gauge_beat_type;

   // shadow of the detection state and the confirm limit
   stbg_kind_type    kind_q;
   logic [CNT_W-1:0] agree_q;
   logic [CNT_W-1:0] limit_q;

   gauge_beat_type pending_beats[$];
   int unsigned mismatch_total;
   int unsigned checked_total;

   // one linear segment of a reserve map; signed, truncating toward zero
   function automatic longint span_map(input longint v, input longint in_lo,
                                       input longint in_hi, input longint out_lo,
                                       input longint out_hi);
      return (v - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
   endfunction

   function automatic logic [PCT_W-1:0] reserve_of_kind(input stbg_kind_type k,
                                                        input logic [MV_W-1:0] mv);
      longint v;
      longint r;
      longint full_mv;
      longint knee_hi_mv;
      longint knee_lo_mv;
      longint empty_mv;
      longint aa_top_mv;
      v = longint'(mv);
      full_mv = longint'(LI_FULL_MV);
      knee_hi_mv = longint'(LI_KNEE_HI_MV);
      knee_lo_mv = longint'(LI_KNEE_LO_MV);
      empty_mv = longint'(EMPTY_MV);
      aa_top_mv = longint'(MAINS_LO_MV);
      case (k)
         KIND_MAINS: r = 100;
         KIND_LITHIUM: begin
            if (v > full_mv)         r = 100;
            else if (v > knee_hi_mv) r = span_map(v, knee_hi_mv, full_mv, 80, 100);
            else if (v > knee_lo_mv) r = span_map(v, knee_lo_mv, knee_hi_mv, 20, 80);
            else if (v > empty_mv)   r = span_map(v, empty_mv, knee_lo_mv, 0, 20);
            else                     r = 0;
         end
         KIND_AA: r = span_map(v, empty_mv, aa_top_mv, 0, 100);
         default: r = 0;
      endcase
      if (r >= 0 && r <= 100) return PCT_W'(r);
      return PCT_ERROR;
   endfunction

   function automatic stbg_alert_type alert_of_kind(input stbg_kind_type k,
                                                    input logic [MV_W-1:0] mv);
      if (k == KIND_LITHIUM) begin
         if (mv < LI_CRIT_MV) return ALERT_CRIT;
         if (mv < LI_LOW_MV) return ALERT_LOW;
      end else if (k == KIND_AA) begin
         if (mv < AA_CRIT_MV) return ALERT_CRIT;
         if (mv < AA_LOW_MV) return ALERT_LOW;
      end
      return ALERT_NONE;
   endfunction

   // advances the shadow state by one reading and returns its result beat
   function automatic gauge_beat_type predict_beat(input logic [ADC_W-1:0] cnt);
      gauge_beat_type beat;
      stbg_kind_type seen;
      logic [MV_W-1:0] mv;
      beat = '0;
      mv = '0;
      if (cnt == '0) begin
         // zero count: nothing computed, state untouched
         beat.bad = 1'b1;
         beat.pct = PCT_ERROR;
         beat.alert = ALERT_NONE;
      end else begin
         mv = MV_NUMERATOR / MV_W'(cnt);
         if (agree_q < limit_q) begin
            if (mv >= MAINS_LO_MV && mv <= MAINS_HI_MV) seen = KIND_MAINS;
            else if (mv > MAINS_HI_MV)                  seen = KIND_LITHIUM;
            else                                        seen = KIND_AA;
            if (kind_q == KIND_UNKNOWN) begin
               kind_q = seen;
               agree_q = CNT_W'(1);
            end else if (kind_q == seen) begin
               if (agree_q < CONFIRM_SAT) agree_q = agree_q + 1'b1;
            end else begin
               kind_q = KIND_UNKNOWN;
            end
         end
         beat.pct = reserve_of_kind(kind_q, mv);
         beat.alert = alert_of_kind(kind_q, mv);
      end
      beat.mv = mv;
      beat.kind = kind_q;
      beat.agree = agree_q;
      beat.mains = (kind_q == KIND_MAINS);
      return beat;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   // result beats are retired before the same edge's reading is predicted
   always @(posedge clock) begin
      gauge_beat_type want;
      if (reset) begin
         kind_q = KIND_UNKNOWN;
         agree_q = '0;
         limit_q = CONFIRM_RESET;
         pending_beats.delete();
      end else begin
         if (csr_wr_en) limit_q = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               $error("result beat with no reading waiting for it");
               mismatch_total++;
            end else begin
               want = pending_beats.pop_front();
               compare_field("supply_mv", 32'(want.mv), 32'(rsp_supply_mv));
               compare_field("supply_kind", 32'(want.kind), 32'(rsp_supply_kind));
               compare_field("confirm_count", 32'(want.agree), 32'(rsp_confirm_count));
               compare_field("reserve_pct", 32'(want.pct), 32'(rsp_reserve_pct));
               compare_field("alert_level", 32'(want.alert), 32'(rsp_alert_level));
               compare_field("on_mains", 32'(want.mains), 32'(rsp_on_mains));
               compare_field("bad_reading", 32'(want.bad), 32'(rsp_bad_reading));
               checked_total++;
            end
         end
         if (req_valid && req_ready) pending_beats.push_back(predict_beat(req_adc_count));
      end
      fail_count <= mismatch_total;
      outstanding <= pending_beats.size();
      beats_checked <= checked_total;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives ADC readings and confirm-limit writes into the supply gauge with
// random gaps and result back-pressure; the checker beside the block does the
// prediction, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import stbg_pkg::*;

   localparam int unsigned PHASE_ITEMS      = 200;
   localparam int unsigned WATCHDOG_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES     = 64;
   localparam int unsigned LONG_HOLD_AFTER  = 300;
   localparam int unsigned LONG_HOLD_CYCLES = 600;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [ADC_W-1:0]   req_adc_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [MV_W-1:0]    rsp_supply_mv;
   logic [1:0]         rsp_supply_kind;
   logic [CNT_W-1:0]   rsp_confirm_count;
   logic [PCT_W-1:0]   rsp_reserve_pct;
   logic [ALERT_W-1:0] rsp_alert_level;
   logic               rsp_on_mains;
   logic               rsp_bad_reading;
   logic               csr_wr_en = 1'b0;
   logic [CNT_W-1:0]   csr_wr_data = '0;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned beats_checked;

   int unsigned readings_sent = 0;
   int unsigned zero_readings = 0;
   int unsigned limit_writes = 0;
   int unsigned steady_left = 0;
   int unsigned quiet_cycles = 0;

   // fresh state, limit 3: walk the type detection into a frozen AA lock
   int unsigned opening_counts [9] = '{0, 1023, 1, 357, 329, 328, 358, 416, 417};
   // map knees, alert thresholds and type borders, plus the extreme counts
   int unsigned boundary_counts [17] = '{1, 267, 268, 285, 312, 313, 321, 322, 357,
                                         375, 376, 406, 411, 417, 418, 1023, 0};
   // rising limits re-arm detection so each phase with a target can lock a new type
   logic [CNT_W-1:0] phase_limits [7] = '{4'd0, 4'd1, 4'd5, 4'd8, 4'd11, 4'd13, 4'd15};
   stbg_kind_type    phase_kinds [7]  = '{KIND_UNKNOWN, KIND_UNKNOWN, KIND_MAINS,
                                          KIND_AA, KIND_LITHIUM, KIND_MAINS, KIND_AA};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   supply_type_and_battery_gauge_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adc_count     (req_adc_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_supply_mv     (rsp_supply_mv),
      .rsp_supply_kind   (rsp_supply_kind),
      .rsp_confirm_count (rsp_confirm_count),
      .rsp_reserve_pct   (rsp_reserve_pct),
      .rsp_alert_level   (rsp_alert_level),
      .rsp_on_mains      (rsp_on_mains),
      .rsp_bad_reading   (rsp_bad_reading),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   stbg_gauge_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adc_count     (req_adc_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_supply_mv     (rsp_supply_mv),
      .rsp_supply_kind   (rsp_supply_kind),
      .rsp_confirm_count (rsp_confirm_count),
      .rsp_reserve_pct   (rsp_reserve_pct),
      .rsp_alert_level   (rsp_alert_level),
      .rsp_on_mains      (rsp_on_mains),
      .rsp_bad_reading   (rsp_bad_reading),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .beats_checked     (beats_checked)
   );

   // ADC count that lands in the given supply class
   function automatic logic [ADC_W-1:0] reading_for_kind(input stbg_kind_type k);
      case (k)
         KIND_LITHIUM: return ($urandom_range(0, 9) < 7) ? ADC_W'($urandom_range(260, 328))
                                                       : ADC_W'($urandom_range(1, 328));
         KIND_MAINS:   return ADC_W'($urandom_range(329, 357));
         default:      return ($urandom_range(0, 9) < 7) ? ADC_W'($urandom_range(358, 430))
                                                       : ADC_W'($urandom_range(358, 1023));
      endcase
   endfunction

   function automatic stbg_kind_type kind_other_than(input stbg_kind_type k);
      stbg_kind_type pick;
      pick = stbg_kind_type'($urandom_range(1, 3));
      while (pick == k) pick = stbg_kind_type'($urandom_range(1, 3));
      return pick;
   endfunction

   // mostly the interesting 2.5..4.7 V band, some full range and zero counts
   function automatic logic [ADC_W-1:0] any_reading(input stbg_kind_type lean);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)  return '0;
      if (roll < 54) return ADC_W'($urandom_range(240, 440));
      if (roll < 80) return ADC_W'($urandom_range(1, 1023));
      if (lean == KIND_UNKNOWN) return reading_for_kind(stbg_kind_type'($urandom_range(1, 3)));
      return reading_for_kind(lean);
   endfunction

   // sender gap: mostly none or short, a few long, with gap-free stretches
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_left != 0) begin
         steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 4);
      if (roll < 98) return $urandom_range(5, 40);
      return $urandom_range(60, 200);
   endfunction

   // holds the beat until accepted, then optionally idles
   task automatic offer_reading(input logic [ADC_W-1:0] cnt);
      int unsigned gap;
      req_adc_count <= cnt;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      readings_sent++;
      if (cnt == '0) zero_readings++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every predicted beat to come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_confirm_limit(input logic [CNT_W-1:0] limit);
      drain_results();
      csr_wr_data <= limit;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_writes++;
   endtask

   // noise, then for a set target a broken run and a clean run of that type to lock it,
   // then boundaries and random readings against whatever is locked
   task automatic run_phase(input logic [CNT_W-1:0] limit, input stbg_kind_type target);
      int unsigned start;
      set_confirm_limit(limit);
      start = readings_sent;
      repeat ($urandom_range(0, 8)) offer_reading(any_reading(KIND_UNKNOWN));
      if (target != KIND_UNKNOWN) begin
         offer_reading(any_reading(KIND_UNKNOWN));
         offer_reading(reading_for_kind(kind_other_than(target)));
         repeat (limit + 1) offer_reading(reading_for_kind(target));
      end
      foreach (boundary_counts[i]) offer_reading(ADC_W'(boundary_counts[i]));
      while (readings_sent - start < PHASE_ITEMS) offer_reading(any_reading(target));
   endtask

   // result side: random ready runs, one long hold-off to back up the block
   initial begin
      int unsigned run_left;
      int unsigned taken;
      int unsigned roll;
      logic run_val;
      bit long_hold_done;
      run_left = 0;
      taken = 0;
      run_val = 1'b1;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (run_left == 0) begin
            roll = $urandom_range(0, 19);
            if (!long_hold_done && taken >= LONG_HOLD_AFTER) begin
               long_hold_done = 1'b1;
               run_val = 1'b0;
               run_left = LONG_HOLD_CYCLES;
            end else if (roll == 0) begin
               run_val = 1'b1;
               run_left = $urandom_range(100, 300);
            end else if (roll < 11) begin
               run_val = 1'b1;
               run_left = $urandom_range(1, 12);
            end else if (roll < 17) begin
               run_val = 1'b0;
               run_left = $urandom_range(1, 3);
            end else if (roll < 19) begin
               run_val = 1'b0;
               run_left = $urandom_range(4, 20);
            end else begin
               run_val = 1'b0;
               run_left = $urandom_range(30, 120);
            end
         end
         rsp_ready <= run_val;
         run_left--;
      end
   end

   // watchdog: ends the run if no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no beat moved for %0d cycles, %0d results outstanding",
                quiet_cycles, outstanding);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening_counts[i]) offer_reading(ADC_W'(opening_counts[i]));
      foreach (boundary_counts[i]) offer_reading(ADC_W'(boundary_counts[i]));
      foreach (phase_limits[p]) run_phase(phase_limits[p], phase_kinds[p]);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d ADC readings (%0d zero counts) over %0d confirm-limit writes",
               readings_sent, zero_readings, limit_writes);
      $display("from 0 to 15, with type locks on mains, AA and lithium; %0d beats checked.",
               beats_checked);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
